@@ rtl/kst_pkg.sv @@
// ============================================================================
// kst_pkg
// Shared types, codes and the control store of the keyed slot table.
// ============================================================================
package kst_pkg;

    // Default number of slots in each key table.
    localparam int KST_SLOTS = 64;

    // Widths fixed by the request and response formats.
    localparam int KEY_W    = 32;
    localparam int SLOT_W   = 6;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2,
        OP_FREE   = 2'd3
    } kst_op_e;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EXISTS  = 2'd1,
        ST_FULL    = 2'd2,
        ST_MISSING = 2'd3
    } kst_status_e;

    // Jump conditions tested by the sequencer.
    typedef enum logic [2:0] {
        C_ALWAYS      = 3'd0,
        C_ACCEPT      = 3'd1,
        C_CLR_LAST    = 3'd2,
        C_REMOVE_ALL  = 3'd3,
        C_SCAN_STOP   = 3'd4,
        C_OUT_BLOCKED = 3'd5,
        C_WIPE_LAST   = 3'd6
    } kst_cond_e;

    typedef logic [3:0] kst_upc_t;

    // Control store addresses.
    localparam kst_upc_t U_CLR      = 4'd0;
    localparam kst_upc_t U_IDLE     = 4'd1;
    localparam kst_upc_t U_DISPATCH = 4'd2;
    localparam kst_upc_t U_ISSUE    = 4'd3;
    localparam kst_upc_t U_SCAN     = 4'd4;
    localparam kst_upc_t U_FIN      = 4'd5;
    localparam kst_upc_t U_HOLD     = 4'd6;
    localparam kst_upc_t U_WIPE     = 4'd7;
    localparam kst_upc_t U_WIPE_END = 4'd8;

    // One control word: datapath strobes plus a conditional jump.
    typedef struct packed {
        logic      ready;   // take a new request
        logic      rd;      // read slot at the index, advance the index
        logic      cmp;     // compare the slot read in the previous step
        logic      wipe;    // write zero at the index, advance the index
        logic      clr;     // write zero at the clear counter after reset
        logic      finish;  // commit a write and load the response
        kst_cond_e cond;
        logic      neg;     // jump when the condition is false
        kst_upc_t  target;
    } kst_uword_t;

    // Condition inputs from the datapath.
    typedef struct packed {
        logic accept;
        logic clr_last;
        logic remove_all;
        logic scan_stop;
        logic out_blocked;
        logic wipe_last;
    } kst_flags_t;

    function automatic kst_uword_t kst_uword(
        input logic      ready,
        input logic      rd,
        input logic      cmp,
        input logic      wipe,
        input logic      clr,
        input logic      finish,
        input kst_cond_e cond,
        input logic      neg,
        input kst_upc_t  target
    );
        kst_uword_t w;
        w.ready  = ready;
        w.rd     = rd;
        w.cmp    = cmp;
        w.wipe   = wipe;
        w.clr    = clr;
        w.finish = finish;
        w.cond   = cond;
        w.neg    = neg;
        w.target = target;
        return w;
    endfunction

    // The microprogram. A step jumps to target when (cond XOR neg) holds,
    // otherwise it falls through to the next address.
    function automatic kst_uword_t kst_urom(input kst_upc_t addr);
        kst_uword_t w;
        unique case (addr)
            U_CLR:      w = kst_uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0,
                                      C_CLR_LAST, 1'b1, U_CLR);
            U_IDLE:     w = kst_uword(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      C_ACCEPT, 1'b1, U_IDLE);
            U_DISPATCH: w = kst_uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      C_REMOVE_ALL, 1'b0, U_WIPE);
            U_ISSUE:    w = kst_uword(1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0,
                                      C_ALWAYS, 1'b1, U_SCAN);
            U_SCAN:     w = kst_uword(1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0,
                                      C_SCAN_STOP, 1'b1, U_SCAN);
            U_FIN:      w = kst_uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1,
                                      C_OUT_BLOCKED, 1'b1, U_IDLE);
            U_HOLD:     w = kst_uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      C_ALWAYS, 1'b0, U_FIN);
            U_WIPE:     w = kst_uword(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0,
                                      C_WIPE_LAST, 1'b1, U_WIPE);
            U_WIPE_END: w = kst_uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      C_ALWAYS, 1'b0, U_FIN);
            default:    w = kst_uword(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                                      C_ALWAYS, 1'b0, U_IDLE);
        endcase
        return w;
    endfunction

endpackage

@@ rtl/keyed_slot_table_core.sv @@
// ============================================================================
// keyed_slot_table_core
// Two tables of 32-bit keys with lookup, insert, remove and find-free
// requests, scanned one slot per cycle under microcode control.
// ============================================================================
//
//  Channel   Direction  Handshake            Contents
//  -------   ---------  -------------------  ----------------------------------
//  s_*       in         s_tvalid / s_tready  request: operation, key, table_select
//  m_*       out        m_tvalid / m_tready  response: status, slot_index
//
// A request scans slots up to the first hit or the last slot; the single
// memory read port sets the one-slot-per-cycle scan. Remove with key zero
// wipes every slot of the selected table instead of scanning.
// After reset a clearing pass over all 2 * 2^ceil(log2(SLOTS)) memory words
// (128 by default) zeroes both tables before the first request is taken.
// A new request is taken while an earlier response still waits; a stalled
// response holds the sequencer in its final steps, U_FIN and U_HOLD.
//
module keyed_slot_table_core #(
    parameter int SLOTS = kst_pkg::KST_SLOTS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kst_pkg::S_DATA_W-1:0]  s_tdata,   // [1:0] operation, [33:2] key
    input  logic [0:0]                    s_tuser,   // [0] table_select
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kst_pkg::M_DATA_W-1:0]  m_tdata    // [1:0] status, [7:2] slot_index
);
    import kst_pkg::*;

    localparam int IDX_W     = $clog2(SLOTS);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int MEM_DEPTH = 2 << IDX_W;

    kst_uword_t ctl;
    kst_flags_t flags;

    // Captured request.
    kst_op_e            op_reg;
    logic               sel_reg;
    logic [KEY_W-1:0]   key_reg;

    // Scan state.
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    logic [IDX_W-1:0]   found_idx_reg;
    logic [IDX_W-1:0]   free_idx_reg;
    logic               found_reg;
    logic               free_found_reg;
    logic [ADDR_W-1:0]  clr_reg;

    // Key memory, both tables side by side.
    logic [KEY_W-1:0]   mem [MEM_DEPTH];
    logic [KEY_W-1:0]   rd_data_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [KEY_W-1:0]   wr_data;

    // Response register.
    logic               out_valid_reg;
    kst_status_e        out_status_reg;
    logic [SLOT_W-1:0]  out_slot_reg;

    logic               load;
    logic               fin_go;
    logic               key_zero;
    logic               match;
    logic               is_free;
    logic               hit;
    logic               cmp_last;
    kst_status_e        fin_status;
    logic [SLOT_W-1:0]  fin_slot;
    logic               fin_write;
    logic [IDX_W-1:0]   fin_idx;
    logic [KEY_W-1:0]   fin_data;

    kst_sequencer u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    // Handshake and compare logic.
    assign s_tready = ctl.ready;
    assign load     = ctl.ready & s_tvalid;
    assign key_zero = (key_reg == '0);
    assign match    = (rd_data_reg == key_reg) && !key_zero;
    assign is_free  = (rd_data_reg == '0);
    assign hit      = (op_reg == OP_FREE) ? is_free : match;
    assign cmp_last = (cmp_idx_reg == IDX_W'(SLOTS - 1));
    assign fin_go   = ctl.finish && !flags.out_blocked;

    // Condition flags for the sequencer.
    always_comb
    begin
        flags.accept      = s_tvalid;
        flags.clr_last    = (clr_reg == '1);
        flags.remove_all  = (op_reg == OP_REMOVE) && key_zero;
        flags.scan_stop   = hit || cmp_last;
        flags.out_blocked = out_valid_reg && !m_tready;
        flags.wipe_last   = (idx_reg == IDX_W'(SLOTS - 1));
    end

    // Response and commit write from the scan results.
    always_comb
    begin
        fin_status = ST_MISSING;
        fin_slot   = '0;
        fin_write  = 1'b0;
        fin_idx    = found_idx_reg;
        fin_data   = '0;
        unique case (op_reg)
            OP_LOOKUP:
            begin
                if (found_reg)
                begin
                    fin_status = ST_OK;
                    fin_slot   = SLOT_W'(found_idx_reg);
                end
            end
            OP_INSERT:
            begin
                if (found_reg)
                begin
                    fin_status = ST_EXISTS;
                    fin_slot   = SLOT_W'(found_idx_reg);
                end
                else if (free_found_reg)
                begin
                    fin_status = ST_OK;
                    fin_slot   = SLOT_W'(free_idx_reg);
                    fin_write  = 1'b1;
                    fin_idx    = free_idx_reg;
                    fin_data   = key_reg;
                end
                else
                begin
                    fin_status = ST_FULL;
                end
            end
            OP_REMOVE:
            begin
                if (key_zero)
                begin
                    fin_status = ST_OK;
                end
                else if (found_reg)
                begin
                    fin_status = ST_OK;
                    fin_slot   = SLOT_W'(found_idx_reg);
                    fin_write  = 1'b1;
                end
            end
            OP_FREE:
            begin
                if (free_found_reg)
                begin
                    fin_status = ST_OK;
                    fin_slot   = SLOT_W'(free_idx_reg);
                end
            end
            default:
            begin
                fin_status = ST_MISSING;
            end
        endcase
    end

    // Memory write port: clearing pass, table wipe, or commit.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = {sel_reg, fin_idx};
        wr_data = '0;
        priority if (ctl.clr)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_reg;
        end
        else if (ctl.wipe)
        begin
            wr_en   = 1'b1;
            wr_addr = {sel_reg, idx_reg};
        end
        else if (fin_go && fin_write)
        begin
            wr_en   = 1'b1;
            wr_data = fin_data;
        end
    end

    assign rd_addr = {sel_reg, idx_reg};

    // Key memory with registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Request capture.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            op_reg  <= kst_op_e'(s_tdata[1:0]);
            key_reg <= s_tdata[KEY_W+1:2];
            sel_reg <= s_tuser[0];
        end
    end

    // Clearing pass counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (ctl.clr)
        begin
            clr_reg <= clr_reg + ADDR_W'(1);
        end
    end

    // Slot index and scan results.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            cmp_idx_reg    <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            found_idx_reg  <= '0;
            free_idx_reg   <= '0;
        end
        else if (load)
        begin
            idx_reg        <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (ctl.rd || ctl.wipe)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
            if (ctl.rd)
            begin
                cmp_idx_reg <= idx_reg;
            end
            if (ctl.cmp)
            begin
                if (match && !found_reg)
                begin
                    found_reg     <= 1'b1;
                    found_idx_reg <= cmp_idx_reg;
                end
                if (is_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                    free_idx_reg   <= cmp_idx_reg;
                end
            end
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin_go)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fin_go)
        begin
            out_status_reg <= fin_status;
            out_slot_reg   <= fin_slot;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_slot_reg, out_status_reg};

endmodule

@@ rtl/kst_sequencer.sv @@
// ============================================================================
// kst_sequencer
// Step counter, control store and jump logic of the keyed slot table.
// ============================================================================
module kst_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  kst_pkg::kst_flags_t flags,
    output kst_pkg::kst_uword_t ctl
);
    import kst_pkg::*;

    kst_upc_t upc_reg;
    kst_upc_t upc_next;
    logic     cond_hit;

    // Current control word.
    assign ctl = kst_urom(upc_reg);

    // Select the tested condition.
    always_comb
    begin
        unique case (ctl.cond)
            C_ALWAYS:      cond_hit = 1'b1;
            C_ACCEPT:      cond_hit = flags.accept;
            C_CLR_LAST:    cond_hit = flags.clr_last;
            C_REMOVE_ALL:  cond_hit = flags.remove_all;
            C_SCAN_STOP:   cond_hit = flags.scan_stop;
            C_OUT_BLOCKED: cond_hit = flags.out_blocked;
            C_WIPE_LAST:   cond_hit = flags.wipe_last;
            default:       cond_hit = 1'b1;
        endcase
    end

    // Jump or fall through.
    always_comb
    begin
        if (cond_hit ^ ctl.neg)
        begin
            upc_next = ctl.target;
        end
        else
        begin
            upc_next = upc_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= U_CLR;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ bench/keyed_slot_table_core_checker.sv @@
`timescale 1ns / 100ps
// ============================================================================
// keyed_slot_table_core_checker
// Watches the request and response streams of the keyed slot table, keeps
// its own copy of both key tables, and checks every response in order.
// ============================================================================
module keyed_slot_table_core_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [kst_pkg::S_DATA_W-1:0]  s_tdata,      // [1:0] operation, [33:2] key
    input  logic [0:0]                    s_tuser,      // [0] table_select
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [kst_pkg::M_DATA_W-1:0]  m_tdata,      // [1:0] status, [7:2] slot_index
    output int                            error_count,
    output int                            pending
);
    import kst_pkg::*;

    typedef struct packed {
        kst_status_e         status;
        logic [SLOT_W-1:0]   slot;
    } kst_reply_t;

    // Shadow copy of both tables, indexed by table_select.
    logic [KEY_W-1:0] key_table [2][KST_SLOTS];
    kst_reply_t       reply_queue [$];
    int               errors = 0;

    // Lowest slot of the selected table that holds the wanted key, or -1.
    function automatic int first_slot(input logic sel, input logic [KEY_W-1:0] want);
        for (int i = 0; i < KST_SLOTS; i++) begin
            if (key_table[sel][i] == want)
                return i;
        end
        return -1;
    endfunction

    // Applies one request to the shadow tables and returns its response.
    function automatic kst_reply_t apply_request(input kst_op_e op, input logic sel,
                                                 input logic [KEY_W-1:0] key);
        kst_reply_t reply;
        int         pos;
        reply.status = ST_MISSING;
        reply.slot   = '0;
        case (op)
            OP_LOOKUP:
            begin
                // A zero key marks a free slot and is never reported as found.
                pos = (key != '0) ? first_slot(sel, key) : -1;
                if (pos >= 0)
                begin
                    reply.status = ST_OK;
                    reply.slot   = SLOT_W'(pos);
                end
            end
            OP_INSERT:
            begin
                pos = (key != '0) ? first_slot(sel, key) : -1;
                if (pos >= 0)
                begin
                    reply.status = ST_EXISTS;
                    reply.slot   = SLOT_W'(pos);
                end
                else
                begin
                    pos = first_slot(sel, '0);
                    if (pos < 0)
                        reply.status = ST_FULL;
                    else
                    begin
                        // Writing a zero key leaves the slot free.
                        key_table[sel][pos] = key;
                        reply.status = ST_OK;
                        reply.slot   = SLOT_W'(pos);
                    end
                end
            end
            OP_REMOVE:
            begin
                if (key == '0)
                begin
                    // Remove with a zero key empties the whole table.
                    for (int i = 0; i < KST_SLOTS; i++)
                        key_table[sel][i] = '0;
                    reply.status = ST_OK;
                end
                else
                begin
                    pos = first_slot(sel, key);
                    if (pos >= 0)
                    begin
                        key_table[sel][pos] = '0;
                        reply.status = ST_OK;
                        reply.slot   = SLOT_W'(pos);
                    end
                end
            end
            default:
            begin
                pos = first_slot(sel, '0);
                if (pos >= 0)
                begin
                    reply.status = ST_OK;
                    reply.slot   = SLOT_W'(pos);
                end
            end
        endcase
        return reply;
    endfunction

    // Responses are checked before the request of the same edge is predicted.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        kst_reply_t want;
        kst_reply_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < KST_SLOTS; i++)
            begin
                key_table[0][i] = '0;
                key_table[1][i] = '0;
            end
            reply_queue.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.status = kst_status_e'(m_tdata[1:0]);
                got.slot   = m_tdata[2 +: SLOT_W];
                if (reply_queue.size() == 0)
                begin
                    $error("unexpected response transaction: status %0d, slot_index %0d",
                           got.status, got.slot);
                    errors++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, got.status);
                        errors++;
                    end
                    if (got.slot != want.slot)
                    begin
                        $error("slot_index mismatch: expected %0d, actual %0d",
                               want.slot, got.slot);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                reply_queue.push_back(apply_request(kst_op_e'(s_tdata[1:0]), s_tuser[0],
                                                    s_tdata[2 +: KEY_W]));
        end
        error_count <= errors;
        pending     <= reply_queue.size();
    end

endmodule

@@ bench/keyed_slot_table_core_tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// keyed_slot_table_core_tb
// Drives directed and random table requests into the keyed slot table with
// random gaps and response stalls; the checker beside it judges the results.
// ============================================================================
module keyed_slot_table_core_tb;
    import kst_pkg::*;

    localparam int ROUNDS       = 14;
    localparam int ROUND_ITEMS  = 125;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = KST_SLOTS + 16;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;       // [1:0] operation, [33:2] key
    logic [0:0]          s_tuser;       // [0] table_select
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;       // [1:0] status, [7:2] slot_index
    int                  error_count;
    int                  pending;
    int                  cycle_count = 0;
    bit                  idle_on = 1'b1;

    keyed_slot_table_core #(
        .SLOTS(KST_SLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    keyed_slot_table_core_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .error_count (error_count),
        .pending     (pending)
    );

    always #4 clk = ~clk;

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Response side: ready stretches and random stall bursts in random order.
    initial
    begin
        forever
        begin
            if (idle_on && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Sends one request transaction, with an occasional gap in front of it.
    task automatic send_request(input kst_op_e op, input logic sel,
                                input logic [KEY_W-1:0] key);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_DATA_W - KEY_W - 2){1'b0}}, key, op};
        s_tuser  <= sel;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [KEY_W-1:0] key_pool [128];
        int               pool_size;
        int               ins_w;
        int               rem_w;
        int               pick;
        logic             round_sel;
        logic             sel;
        logic [KEY_W-1:0] key;
        kst_op_e          op;

        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        pool_size = 1;
        round_sel = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed requests: key extremes, every operation, zero-key corners.
        send_request(OP_LOOKUP, 1'b0, 32'h0000_0000);
        send_request(OP_FREE,   1'b0, 32'h0000_0000);
        send_request(OP_INSERT, 1'b0, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 1'b0, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 1'b0, 32'hFFFF_FFFF);
        send_request(OP_LOOKUP, 1'b1, 32'hFFFF_FFFF);
        send_request(OP_INSERT, 1'b1, 32'h0000_0001);
        send_request(OP_INSERT, 1'b0, 32'h8000_0000);
        send_request(OP_INSERT, 1'b0, 32'h0000_0000);
        send_request(OP_FREE,   1'b0, 32'h0000_0000);
        send_request(OP_REMOVE, 1'b0, 32'hFFFF_FFFF);
        send_request(OP_REMOVE, 1'b0, 32'hFFFF_FFFF);
        send_request(OP_FREE,   1'b0, 32'h0000_0000);
        send_request(OP_LOOKUP, 1'b0, 32'h8000_0000);
        send_request(OP_REMOVE, 1'b1, 32'h0000_0000);
        send_request(OP_LOOKUP, 1'b1, 32'h0000_0001);
        send_request(OP_FREE,   1'b1, 32'hFFFF_FFFF);

        // Random rounds. Each round has a profile; fill rounds drive a table
        // to full and the drain rounds after them remove the same keys.
        for (int round = 0; round < ROUNDS; round++)
        begin
            idle_on = (round != ROUNDS - 1);
            // Drain rounds stay on the table of the fill round before them.
            if (round % 4 != 2)
                round_sel = 1'($urandom_range(0, 1));
            case (round % 4)
                0:
                begin
                    pool_size = $urandom_range(24, 64);
                    ins_w = 35;
                    rem_w = 15;
                end
                1:
                begin
                    pool_size = 120;
                    ins_w = 85;
                    rem_w = 3;
                end
                2:
                begin
                    ins_w = 15;
                    rem_w = 55;
                end
                default:
                begin
                    pool_size = $urandom_range(4, 16);
                    ins_w = 30;
                    rem_w = 25;
                end
            endcase
            // Drain rounds keep the pool of the fill round before them.
            if (round % 4 != 2)
            begin
                for (int i = 0; i < pool_size; i++)
                begin
                    do
                        key_pool[i] = $urandom;
                    while (key_pool[i] == '0);
                end
            end

            for (int n = 0; n < ROUND_ITEMS; n++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < ins_w)
                    op = OP_INSERT;
                else if (pick < ins_w + rem_w)
                    op = OP_REMOVE;
                else if (pick < ins_w + rem_w + (100 - ins_w - rem_w) / 2)
                    op = OP_LOOKUP;
                else
                    op = OP_FREE;
                sel = ($urandom_range(0, 4) == 0) ? ~round_sel : round_sel;
                key = key_pool[$urandom_range(0, pool_size - 1)];
                // Noise: keys that are almost never present, and zero keys.
                if ($urandom_range(0, 11) == 0)
                    key = $urandom;
                if ($urandom_range(0, 79) == 0)
                    key = '0;
                send_request(op, sel, key);
            end
        end
        s_tvalid <= 1'b0;

        // Wait for the last responses, then let the block settle.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
